// ===== sv/lpht_pkg.sv =====
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int SLOTS_DEF      = 1024;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int SIZE_W  = 4;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd10;
  localparam logic [SIZE_W-1:0] SIZE_LOG2_MIN = 4'd3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] OCC_EMPTY = 2'd0;
  localparam logic [1:0] OCC_LIVE  = 2'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hash;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        key_out;
    logic [63:0]        value_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic re;
    logic we_occ;
    logic we_data;
  } mem_ctl_t;

endpackage

// ===== sv/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table with its configuration port.
`timescale 1ns / 1ps
// After reset the block clears the occupancy memory of every slot with busy
// high. An operation is taken when start is high and busy is low; insert,
// find and next then probe from one slot up to the active table size, each
// slot passing through a read state for the synchronous memory read and a
// check state that tests the slot. Next on an empty table and unknown commands
// answer in the cycle after they are taken. Each result word appears on
// rsp_o for a single cycle with rsp_valid_o high and must be captured then.
module linear_probe_hash_table #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lpht_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output lpht_pkg::rsp_t rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int AW = $clog2(SLOTS);

  logic [lpht_pkg::SIZE_W-1:0] size_q;
  lpht_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  logic [1:0]                  wocc;
  logic [31:0]                 whash;
  logic [KEY_BITS-1:0]         wkey;
  logic [VALUE_BITS-1:0]       wval;
  logic [1:0]                  rocc;
  logic [31:0]                 rhash;
  logic [KEY_BITS-1:0]         rkey;
  logic [VALUE_BITS-1:0]       rval;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lpht_pkg::SIZE_LOG2_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      size_q <= pwdata[lpht_pkg::SIZE_W-1:0];
    end
  end

  lpht_ctrl #(
    .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .size_log2_i(size_q),
    .start_i(start), .req_i(req_i), .busy_o(busy),
    .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o),
    .mem_ctl_o(mem_ctl), .raddr_o(raddr), .waddr_o(waddr), .wocc_o(wocc),
    .whash_o(whash), .wkey_o(wkey), .wval_o(wval),
    .rocc_i(rocc), .rhash_i(rhash), .rkey_i(rkey), .rval_i(rval)
  );

  lpht_mem #(
    .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_mem (
    .clk_i(clk_i), .ctl_i(mem_ctl), .raddr_i(raddr), .waddr_i(waddr),
    .wocc_i(wocc), .whash_i(whash), .wkey_i(wkey), .wval_i(wval),
    .rocc_o(rocc), .rhash_o(rhash), .rkey_o(rkey), .rval_o(rval)
  );

endmodule

// ===== sv/lpht_mem.sv =====
// Slot storage: occupancy, hash, key and value arrays with a registered read.
`timescale 1ns / 1ps
module lpht_mem #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
  localparam int AW        = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  lpht_pkg::mem_ctl_t    ctl_i,
  input  logic [AW-1:0]         raddr_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [1:0]            wocc_i,
  input  logic [31:0]           whash_i,
  input  logic [KEY_BITS-1:0]   wkey_i,
  input  logic [VALUE_BITS-1:0] wval_i,
  output logic [1:0]            rocc_o,
  output logic [31:0]           rhash_o,
  output logic [KEY_BITS-1:0]   rkey_o,
  output logic [VALUE_BITS-1:0] rval_o
);

  logic [1:0]            occ_mem [SLOTS];
  logic [31:0]           hash_mem[SLOTS];
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_occ) begin
      occ_mem[waddr_i] <= wocc_i;
    end
    if (ctl_i.we_data) begin
      hash_mem[waddr_i] <= whash_i;
      key_mem[waddr_i]  <= wkey_i;
      val_mem[waddr_i]  <= wval_i;
    end
    if (ctl_i.re) begin
      rocc_o  <= occ_mem[raddr_i];
      rhash_o <= hash_mem[raddr_i];
      rkey_o  <= key_mem[raddr_i];
      rval_o  <= val_mem[raddr_i];
    end
  end

endmodule

// ===== sv/lpht_ctrl.sv =====
// Probe sequencer: clears occupancy, walks slots and forms each result word.
`timescale 1ns / 1ps
module lpht_ctrl #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
  localparam int AW        = $clog2(SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpht_pkg::SIZE_W-1:0]   size_log2_i,
  input  logic                          start_i,
  input  lpht_pkg::req_t                req_i,
  output logic                          busy_o,
  output logic                          rsp_valid_o,
  output lpht_pkg::rsp_t                rsp_o,
  output lpht_pkg::mem_ctl_t            mem_ctl_o,
  output logic [AW-1:0]                 raddr_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [1:0]                    wocc_o,
  output logic [31:0]                   whash_o,
  output logic [KEY_BITS-1:0]           wkey_o,
  output logic [VALUE_BITS-1:0]         wval_o,
  input  logic [1:0]                    rocc_i,
  input  logic [31:0]                   rhash_i,
  input  logic [KEY_BITS-1:0]           rkey_i,
  input  logic [VALUE_BITS-1:0]         rval_i
);

  localparam int FIT_LOG2 = $clog2(SLOTS + 1) - 1;
  localparam int TOP_LOG2 = (FIT_LOG2 < 10) ? FIT_LOG2 : 10;
  localparam int CW       = TOP_LOG2 + 1;
  localparam logic [lpht_pkg::SIZE_W-1:0] TOP_SIZE = lpht_pkg::SIZE_W'(TOP_LOG2);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK} state_e;

  state_e                         state_q;
  logic [AW-1:0]                  clr_q;
  logic [AW-1:0]                  idx_q;
  logic [AW-1:0]                  cursor_q;
  logic [CW-1:0]                  cnt_q;
  logic [lpht_pkg::COUNT_W-1:0]   live_q;
  logic [1:0]                     cmd_q;
  logic [31:0]                    hash_q;
  logic [KEY_BITS-1:0]            key_q;
  logic [VALUE_BITS-1:0]          val_q;
  logic                           rsp_valid_q;
  lpht_pkg::rsp_t                 rsp_q;

  logic [lpht_pkg::SIZE_W-1:0]    lg;
  logic [AW-1:0]                  mask;
  logic [CW-1:0]                  last_cnt;
  logic [AW-1:0]                  idx_nx;
  logic                           last;
  logic                           take;

  always_comb begin
    lg = size_log2_i;
    if (lg < lpht_pkg::SIZE_LOG2_MIN) begin
      lg = lpht_pkg::SIZE_LOG2_MIN;
    end
    if (lg > TOP_SIZE) begin
      lg = TOP_SIZE;
    end
    mask     = AW'((32'd1 << lg) - 32'd1);
    last_cnt = CW'((32'd1 << lg) - 32'd1);
    idx_nx   = (idx_q + AW'(1)) & mask;
    last     = (cnt_q == last_cnt);
    take     = (state_q == S_CHECK) && (cmd_q == lpht_pkg::CMD_INSERT) &&
               (rocc_i != lpht_pkg::OCC_LIVE);
  end

  always_comb begin
    mem_ctl_o.re      = (state_q == S_READ);
    mem_ctl_o.we_occ  = (state_q == S_CLEAR) || take;
    mem_ctl_o.we_data = take;
    raddr_o           = idx_q;
    waddr_o           = (state_q == S_CLEAR) ? clr_q : idx_q;
    wocc_o            = (state_q == S_CLEAR) ? lpht_pkg::OCC_EMPTY : lpht_pkg::OCC_LIVE;
    whash_o           = hash_q;
    wkey_o            = key_q;
    wval_o            = val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      cursor_q    <= '0;
      cnt_q       <= '0;
      live_q      <= '0;
      cmd_q       <= '0;
      hash_q      <= '0;
      key_q       <= '0;
      val_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            cmd_q  <= req_i.command;
            hash_q <= req_i.hash;
            key_q  <= req_i.key[KEY_BITS-1:0];
            val_q  <= req_i.value[VALUE_BITS-1:0];
            cnt_q  <= '0;
            if (req_i.command == lpht_pkg::CMD_NEXT) begin
              idx_q <= (cursor_q + AW'(1)) & mask;
            end else begin
              idx_q <= AW'(req_i.hash) & mask;
            end
            if (req_i.command == lpht_pkg::CMD_NEXT && live_q == '0) begin
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{lpht_pkg::ST_EMPTY, lpht_pkg::SLOT_W'(cursor_q),
                               64'd0, 64'd0, live_q};
            end else if (req_i.command != lpht_pkg::CMD_INSERT &&
                         req_i.command != lpht_pkg::CMD_FIND &&
                         req_i.command != lpht_pkg::CMD_NEXT) begin
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{lpht_pkg::ST_MISS, '0, 64'd0, 64'd0, live_q};
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= S_IDLE;
          case (cmd_q)
            lpht_pkg::CMD_INSERT: begin
              if (take) begin
                live_q      <= live_q + lpht_pkg::COUNT_W'(1);
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_OK, lpht_pkg::SLOT_W'(idx_q),
                                 64'(key_q), 64'(val_q),
                                 live_q + lpht_pkg::COUNT_W'(1)};
              end else if (last) begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_FULL, '0, 64'd0, 64'd0, live_q};
              end else begin
                idx_q   <= idx_nx;
                cnt_q   <= cnt_q + CW'(1);
                state_q <= S_READ;
              end
            end
            lpht_pkg::CMD_FIND: begin
              if (rocc_i == lpht_pkg::OCC_LIVE && rhash_i == hash_q && rkey_i == key_q) begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_OK, lpht_pkg::SLOT_W'(idx_q),
                                 64'(rkey_i), 64'(rval_i), live_q};
              end else if (rocc_i == lpht_pkg::OCC_EMPTY || last) begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_MISS, '0, 64'd0, 64'd0, live_q};
              end else begin
                idx_q   <= idx_nx;
                cnt_q   <= cnt_q + CW'(1);
                state_q <= S_READ;
              end
            end
            default: begin
              if (rocc_i == lpht_pkg::OCC_LIVE) begin
                cursor_q    <= idx_q;
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_OK, lpht_pkg::SLOT_W'(idx_q),
                                 64'(rkey_i), 64'(rval_i), live_q};
              end else if (last) begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{lpht_pkg::ST_EMPTY, lpht_pkg::SLOT_W'(cursor_q),
                                 64'd0, 64'd0, live_q};
              end else begin
                idx_q   <= idx_nx;
                cnt_q   <= cnt_q + CW'(1);
                state_q <= S_READ;
              end
            end
          endcase
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (state_q == S_IDLE))
    else $error("result word outside idle");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(live_q) <= SLOTS))
    else $error("live count above slot count");
  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status == lpht_pkg::ST_FULL) |-> (live_q == $past(live_q)))
    else $error("full insert changed live count");
  a_write_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.we_data |=> (rsp_valid_q && rsp_q.status == lpht_pkg::ST_OK))
    else $error("slot write without ok result");
`endif

endmodule
